FILE: rtl/core/hfs_pkg.sv
package hfs_pkg;

   // default sizing
   localparam int unsigned GRID_MAX_DEF  = 256;
   localparam int unsigned FRAC_BITS_DEF = 8;

   // field widths
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned CELL_W   = 13;
   localparam int unsigned SAMPLE_W = 21;
   localparam int unsigned HGT_W    = 16;
   localparam int unsigned ATTR_W   = 8;
   localparam int unsigned TAG_W    = ATTR_W + 1;
   localparam int unsigned OUT_W    = 18;
   localparam int unsigned GSIZE_W  = 9;

   // register port
   localparam int unsigned PADDR_W = 3;
   localparam int unsigned PDATA_W = 32;
   localparam logic        CSR_IDX_GRID_SIZE = 1'b0;
   localparam logic [GSIZE_W-1:0] GSIZE_RESET = 9'd256;

   // result saturation bounds
   localparam int OUT_MAX = 131071;
   localparam int OUT_MIN = -131072;

   // item modes
   localparam logic [MODE_W-1:0] MODE_WR_HEIGHT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_WR_CUT    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_WR_ATTR  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_RD_NEAR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RD_INTERP = 3'd4;

endpackage

FILE: rtl/core/hfs_ram.sv
module hfs_ram #(
   parameter int unsigned WIDTH = hfs_pkg::HGT_W,
   parameter int unsigned DEPTH = hfs_pkg::GRID_MAX_DEF * hfs_pkg::GRID_MAX_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/heightfield_store_sampler.sv
// Height grid store with nearest and interpolated reads.
// Input channel req_*: one item per handshake (valid and ready). Modes 0..2
// write the height, cut bit or attribute of one cell and give no result;
// writes outside the grid and modes 5..7 are dropped. Mode 3 returns the
// clamped cell, mode 4 a floored, saturated interpolated height.
// Result channel rsp_*: one item per read, held in an output register.
// The grid size register sits at byte address 0 of the APB-style port.
// Items are worked one at a time, each through the clamp and base states;
// a dropped item then goes idle, a height write is written in fetch, a cut
// or attribute write reads in fetch and writes in merge (read-modify-write
// of the shared cut/attribute memory), a nearest read fetches and emits,
// and an interpolated read fetches its three corner heights one a cycle
// from the single port of the height memory, then multiplies, sums, emits.
// A new item is taken while a result still waits; if the receiver stalls,
// the next read holds in its last stage until the output register frees.
// Synchronous reset empties the pipeline and the output register and sets
// the grid size to 256; the memories are not cleared and must be written
// before they are read.
module heightfield_store_sampler #(
   parameter int unsigned GRID_MAX  = hfs_pkg::GRID_MAX_DEF,
   parameter int unsigned FRAC_BITS = hfs_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [hfs_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [hfs_pkg::CELL_W-1:0]   req_cell_x,
   input  logic signed [hfs_pkg::CELL_W-1:0]   req_cell_z,
   input  logic signed [hfs_pkg::SAMPLE_W-1:0] req_sample_x,
   input  logic signed [hfs_pkg::SAMPLE_W-1:0] req_sample_z,
   input  logic [hfs_pkg::HGT_W-1:0]           req_height_in,
   input  logic                                req_cut_in,
   input  logic [hfs_pkg::ATTR_W-1:0]          req_attribute_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hfs_pkg::OUT_W-1:0]    rsp_height_out,
   output logic                                rsp_cut_out,
   output logic [hfs_pkg::ATTR_W-1:0]          rsp_attribute_out,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hfs_pkg::PADDR_W-1:0]         paddr,
   input  logic [hfs_pkg::PDATA_W-1:0]         pwdata,
   output logic [hfs_pkg::PDATA_W-1:0]         prdata,
   output logic                                pready
);

   import hfs_pkg::*;

   localparam int unsigned CW    = $clog2(GRID_MAX);
   localparam int unsigned SZW   = $clog2(GRID_MAX + 1);
   localparam int unsigned DEPTH = GRID_MAX * GRID_MAX;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned XW    = ((SAMPLE_W > SZW) ? SAMPLE_W : SZW) + 2;
   localparam int unsigned GCW   = (SZW > GSIZE_W) ? SZW : GSIZE_W;
   localparam int unsigned DW    = HGT_W + 1;
   localparam int unsigned PW    = DW + XW;
   localparam int unsigned SW    = PW + 2;

   localparam logic [1:0] FETCH_H00 = 2'd0;
   localparam logic [1:0] FETCH_MID = 2'd1;
   localparam logic [1:0] FETCH_H11 = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CLAMP = 8'b0000_0010,
      ST_BASE  = 8'b0000_0100,
      ST_FETCH = 8'b0000_1000,
      ST_MERGE = 8'b0001_0000,
      ST_MUL   = 8'b0010_0000,
      ST_SUM   = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

   // control registers
   state_type           state_ff, state_in;
   logic [1:0]          fcnt_ff, fcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [GSIZE_W-1:0]  grid_size_ff, grid_size_in;

   // item registers
   logic [MODE_W-1:0]          mode_ff;
   logic signed [CELL_W-1:0]   cx_ff, cz_ff;
   logic signed [SAMPLE_W-1:0] sx_ff, sz_ff;
   logic [HGT_W-1:0]           hin_ff;
   logic                       cut_ff;
   logic [ATTR_W-1:0]          attr_ff;
   logic [CW-1:0]              xc_ff, xc_in, zc_ff, zc_in;
   logic signed [XW-1:0]       fx_ff, fx_in, fz_ff, fz_in;
   logic                       diag_ff, diag_in;
   logic                       act_ff, act_in;
   logic [AW-1:0]              base_ff, base_in;
   logic [HGT_W-1:0]           h00_ff, hx_ff;
   logic signed [PW-1:0]       pz_ff, pz_in, px_ff, px_in;
   logic signed [OUT_W-1:0]    res_h_ff, res_h_in;
   logic signed [OUT_W-1:0]    rsp_h_ff, rsp_h_in;
   logic                       rsp_cut_ff, rsp_cut_in;
   logic [ATTR_W-1:0]          rsp_attr_ff, rsp_attr_in;

   // combinational
   logic                 csr_wr;
   logic                 emit_load;
   logic                 is_interp;
   logic [GCW-1:0]       gsz_w;
   logic [SZW-1:0]       size_use;
   logic signed [XW-1:0] size_x, lim_near, lim_cell;
   logic signed [XW-1:0] cx_x, cz_x, sx_x, sz_x, flx_x, flz_x;
   logic signed [XW-1:0] nxc, nzc, ixc, izc;
   logic                 in_grid;
   logic [CW+SZW-1:0]    zrow;
   logic [AW-1:0]        fetch_addr;
   logic                 hgt_wr, hgt_rd_en, tag_wr, tag_rd_en;
   logic [HGT_W-1:0]     hgt_rd;
   logic [TAG_W-1:0]     tag_rd, tag_wdata;
   logic signed [DW-1:0] d_lo, d_hi, coef_z, coef_x;
   logic signed [SW-1:0] sum_s, quo_s;

   function automatic logic signed [XW-1:0] clamp_x(
      input logic signed [XW-1:0] v,
      input logic signed [XW-1:0] hi
   );
      logic signed [XW-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[PADDR_W-1] == CSR_IDX_GRID_SIZE);
   assign grid_size_in = csr_wr ? pwdata[GSIZE_W-1:0] : grid_size_ff;
   assign prdata = (paddr[PADDR_W-1] == CSR_IDX_GRID_SIZE) ? PDATA_W'(grid_size_ff) : '0;

   // grid size in use, clamped to 2..GRID_MAX
   assign gsz_w = GCW'(grid_size_ff);
   always_comb begin
      if (gsz_w < GCW'(2)) begin
         size_use = SZW'(2);
      end else if (gsz_w > GCW'(GRID_MAX)) begin
         size_use = SZW'(GRID_MAX);
      end else begin
         size_use = SZW'(gsz_w);
      end
   end

   // coordinate clamping and fractions
   assign size_x   = $signed(XW'(size_use));
   assign lim_near = size_x - XW'(1);
   assign lim_cell = size_x - XW'(2);
   assign cx_x  = $signed({{(XW-CELL_W){cx_ff[CELL_W-1]}}, cx_ff});
   assign cz_x  = $signed({{(XW-CELL_W){cz_ff[CELL_W-1]}}, cz_ff});
   assign sx_x  = $signed({{(XW-SAMPLE_W){sx_ff[SAMPLE_W-1]}}, sx_ff});
   assign sz_x  = $signed({{(XW-SAMPLE_W){sz_ff[SAMPLE_W-1]}}, sz_ff});
   assign flx_x = sx_x >>> FRAC_BITS;
   assign flz_x = sz_x >>> FRAC_BITS;
   assign nxc   = clamp_x(cx_x, lim_near);
   assign nzc   = clamp_x(cz_x, lim_near);
   assign ixc   = clamp_x(flx_x, lim_cell);
   assign izc   = clamp_x(flz_x, lim_cell);
   assign fx_in = sx_x - (ixc <<< FRAC_BITS);
   assign fz_in = sz_x - (izc <<< FRAC_BITS);
   assign diag_in = (fx_in < fz_in);
   assign in_grid = (cx_x >= 0) && (cx_x < size_x) && (cz_x >= 0) && (cz_x < size_x);
   assign is_interp = (mode_ff == MODE_RD_INTERP);
   assign xc_in = is_interp ? CW'(ixc) : CW'(nxc);
   assign zc_in = is_interp ? CW'(izc) : CW'(nzc);

   // mode decode: does the item touch the memories
   always_comb begin
      unique case (mode_ff) inside
         MODE_WR_HEIGHT, MODE_WR_CUT, MODE_WR_ATTR: act_in = in_grid;
         MODE_RD_NEAR, MODE_RD_INTERP:              act_in = 1'b1;
         default:                                   act_in = 1'b0;
      endcase
   end

   // row base address
   assign zrow    = (CW+SZW)'(zc_ff) * (CW+SZW)'(size_use);
   assign base_in = AW'(zrow) + AW'(xc_ff);

   // corner address: h00, then h01 or h10, then h11
   always_comb begin
      case (fcnt_ff)
         FETCH_H00: fetch_addr = base_ff;
         FETCH_MID: fetch_addr = diag_ff ? base_ff + AW'(size_use) : base_ff + AW'(1);
         default:   fetch_addr = base_ff + AW'(size_use) + AW'(1);
      endcase
   end

   // memory controls
   assign hgt_wr    = (state_ff == ST_FETCH) && (mode_ff == MODE_WR_HEIGHT);
   assign hgt_rd_en = (state_ff == ST_FETCH)
                      && ((mode_ff == MODE_RD_NEAR) || (mode_ff == MODE_RD_INTERP));
   assign tag_rd_en = (state_ff == ST_FETCH)
                      && ((mode_ff == MODE_WR_CUT) || (mode_ff == MODE_WR_ATTR)
                          || (mode_ff == MODE_RD_NEAR));
   assign tag_wr    = (state_ff == ST_MERGE);
   assign tag_wdata = (mode_ff == MODE_WR_CUT) ? {cut_ff, tag_rd[ATTR_W-1:0]}
                                                : {tag_rd[ATTR_W], attr_ff};

   hfs_ram #(
      .WIDTH (HGT_W),
      .DEPTH (DEPTH)
   ) u_hgt_ram (
      .clock   (clock),
      .wr_en   (hgt_wr),
      .rd_en   (hgt_rd_en),
      .addr    (fetch_addr),
      .wr_data (hin_ff),
      .rd_data (hgt_rd)
   );

   // cut bit over attribute byte
   hfs_ram #(
      .WIDTH (TAG_W),
      .DEPTH (DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_wr),
      .rd_en   (tag_rd_en),
      .addr    (fetch_addr),
      .wr_data (tag_wdata),
      .rd_data (tag_rd)
   );

   // triangle plane: h00 + coef_z*fz + coef_x*fx, h11 arrives live
   assign d_lo   = $signed({1'b0, hx_ff}) - $signed({1'b0, h00_ff});
   assign d_hi   = $signed({1'b0, hgt_rd}) - $signed({1'b0, hx_ff});
   assign coef_z = diag_ff ? d_lo : d_hi;
   assign coef_x = diag_ff ? d_hi : d_lo;
   assign pz_in  = PW'(coef_z) * PW'(fz_ff);
   assign px_in  = PW'(coef_x) * PW'(fx_ff);

   // sum, floor and saturate
   assign sum_s = SW'(pz_ff) + SW'(px_ff) + $signed(SW'({h00_ff, {FRAC_BITS{1'b0}}}));
   assign quo_s = sum_s >>> FRAC_BITS;
   always_comb begin
      if (quo_s > SW'(OUT_MAX)) begin
         res_h_in = OUT_W'(OUT_MAX);
      end else if (quo_s < SW'(OUT_MIN)) begin
         res_h_in = OUT_W'(OUT_MIN);
      end else begin
         res_h_in = OUT_W'(quo_s);
      end
   end

   // output register load
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   always_comb begin
      if (mode_ff == MODE_RD_NEAR) begin
         rsp_h_in    = $signed(OUT_W'(hgt_rd));
         rsp_cut_in  = tag_rd[ATTR_W];
         rsp_attr_in = tag_rd[ATTR_W-1:0];
      end else begin
         rsp_h_in    = res_h_ff;
         rsp_cut_in  = 1'b0;
         rsp_attr_in = '0;
      end
   end

   always_comb begin
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      fcnt_in  = FETCH_H00;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            state_in = ST_BASE;
         end
         ST_BASE: begin
            state_in = act_ff ? ST_FETCH : ST_IDLE;
         end
         ST_FETCH: begin
            case (mode_ff) inside
               MODE_WR_CUT, MODE_WR_ATTR: state_in = ST_MERGE;
               MODE_RD_NEAR:              state_in = ST_EMIT;
               MODE_RD_INTERP: begin
                  if (fcnt_ff == FETCH_H11) begin
                     state_in = ST_MUL;
                  end else begin
                     fcnt_in = fcnt_ff + 2'd1;
                  end
               end
               default:                   state_in = ST_IDLE;
            endcase
         end
         ST_MERGE: begin
            state_in = ST_IDLE;
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fcnt_ff      <= FETCH_H00;
         rsp_valid_ff <= 1'b0;
         grid_size_ff <= GSIZE_RESET;
      end else begin
         state_ff     <= state_in;
         fcnt_ff      <= fcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         grid_size_ff <= grid_size_in;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff <= req_mode;
         cx_ff   <= req_cell_x;
         cz_ff   <= req_cell_z;
         sx_ff   <= req_sample_x;
         sz_ff   <= req_sample_z;
         hin_ff  <= req_height_in;
         cut_ff  <= req_cut_in;
         attr_ff <= req_attribute_in;
      end
      if (state_ff == ST_CLAMP) begin
         xc_ff   <= xc_in;
         zc_ff   <= zc_in;
         fx_ff   <= fx_in;
         fz_ff   <= fz_in;
         diag_ff <= diag_in;
         act_ff  <= act_in;
      end
      if (state_ff == ST_BASE) begin
         base_ff <= base_in;
      end
      if ((state_ff == ST_FETCH) && (fcnt_ff == FETCH_MID)) begin
         h00_ff <= hgt_rd;
      end
      if ((state_ff == ST_FETCH) && (fcnt_ff == FETCH_H11)) begin
         hx_ff <= hgt_rd;
      end
      if (state_ff == ST_MUL) begin
         pz_ff <= pz_in;
         px_ff <= px_in;
      end
      if (state_ff == ST_SUM) begin
         res_h_ff <= res_h_in;
      end
      if (emit_load) begin
         rsp_h_ff    <= rsp_h_in;
         rsp_cut_ff  <= rsp_cut_in;
         rsp_attr_ff <= rsp_attr_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_height_out    = rsp_h_ff;
   assign rsp_cut_out       = rsp_cut_ff;
   assign rsp_attribute_out = rsp_attr_ff;

endmodule

FILE: rtl/core/hfs_checker.sv
module hfs_port_checks (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [hfs_pkg::OUT_W-1:0] rsp_height_out,
   input logic                             rsp_cut_out,
   input logic [hfs_pkg::ATTR_W-1:0]       rsp_attribute_out,
   input logic                             psel,
   input logic                             penable,
   input logic                             pwrite,
   input logic                             pready,
   input logic [hfs_pkg::PADDR_W-1:0]      paddr,
   input logic [hfs_pkg::PDATA_W-1:0]      pwdata,
   input logic [hfs_pkg::PDATA_W-1:0]      prdata
);

   import hfs_pkg::*;

   // reset leaves the block empty and ready for an item
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

   // one item at a time: no second item on the edge after an acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while the previous one is at work");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_height_out)
                                  && $stable(rsp_cut_out) && $stable(rsp_attribute_out))
      else $error("result changed while stalled");

   // grid size reads back what was written
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && (paddr[PADDR_W-1] == CSR_IDX_GRID_SIZE)
      |=> (paddr[PADDR_W-1] != CSR_IDX_GRID_SIZE)
          || (prdata[GSIZE_W-1:0] == $past(pwdata[GSIZE_W-1:0])))
      else $error("grid size readback mismatch");

endmodule

bind heightfield_store_sampler hfs_port_checks u_hfs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_height_out    (rsp_height_out),
   .rsp_cut_out       (rsp_cut_out),
   .rsp_attribute_out (rsp_attribute_out),
   .psel              (psel),
   .penable           (penable),
   .pwrite            (pwrite),
   .pready            (pready),
   .paddr             (paddr),
   .pwdata            (pwdata),
   .prdata            (prdata)
);

FILE: tb/hfs_checker.sv
`timescale 1ns / 1ps
module hfs_checker #(
   parameter int unsigned GRID_MAX  = hfs_pkg::GRID_MAX_DEF,
   parameter int unsigned FRAC_BITS = hfs_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [hfs_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [hfs_pkg::CELL_W-1:0]   req_cell_x,
   input  logic signed [hfs_pkg::CELL_W-1:0]   req_cell_z,
   input  logic signed [hfs_pkg::SAMPLE_W-1:0] req_sample_x,
   input  logic signed [hfs_pkg::SAMPLE_W-1:0] req_sample_z,
   input  logic [hfs_pkg::HGT_W-1:0]           req_height_in,
   input  logic                                req_cut_in,
   input  logic [hfs_pkg::ATTR_W-1:0]          req_attribute_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [hfs_pkg::OUT_W-1:0]    rsp_height_out,
   input  logic                                rsp_cut_out,
   input  logic [hfs_pkg::ATTR_W-1:0]          rsp_attribute_out,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hfs_pkg::PADDR_W-1:0]         paddr,
   input  logic [hfs_pkg::PDATA_W-1:0]         pwdata,
   input  logic                                pready,
   output int                                  fail_count,
   output int                                  outstanding
);
   import hfs_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] height;
      logic                    cut;
      logic [ATTR_W-1:0]       attr;
   } sample_type;

   localparam longint UNIT = longint'(1) << FRAC_BITS;
   localparam int CELLS = GRID_MAX * GRID_MAX;

   // shadow copy of the grid and the size register
   logic [HGT_W-1:0]   height_mem [CELLS];
   logic               cut_mem    [CELLS];
   logic [ATTR_W-1:0]  attr_mem   [CELLS];
   logic [GSIZE_W-1:0] grid_reg;
   sample_type         expected_samples [$];

   function automatic longint clamp_l(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint span_in_use();
      return clamp_l(longint'(grid_reg), 2, GRID_MAX);
   endfunction

   // triangle split of the cell, linear along z then x, floored and saturated
   function automatic longint blend_height(longint sx, longint sz, longint span);
      longint ix, iz, fx, fz, base;
      longint h00, h10, h01, h11;
      longint left, right, total;
      ix = clamp_l(sx >>> FRAC_BITS, 0, span - 2);
      iz = clamp_l(sz >>> FRAC_BITS, 0, span - 2);
      fx = sx - ix * UNIT;
      fz = sz - iz * UNIT;
      base = ix + iz * span;
      h00 = longint'(height_mem[base]);
      h10 = longint'(height_mem[base + 1]);
      h01 = longint'(height_mem[base + span]);
      h11 = longint'(height_mem[base + span + 1]);
      // rebuild the corner off the diagonal at full precision
      if (fx < fz) h10 = h00 + h11 - h01;
      else h01 = h11 + h00 - h10;
      left  = h00 * UNIT + (h01 - h00) * fz;
      right = h10 * UNIT + (h11 - h10) * fz;
      total = left * UNIT + (right - left) * fx;
      return clamp_l(total >>> (2 * FRAC_BITS), OUT_MIN, OUT_MAX);
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      fail_count++;
      $display("hfs_checker: %s mismatch, got %0d expected %0d", what, got, want);
   endtask

   always @(posedge clock) begin : monitor
      sample_type want;
      longint     cx, cz, span;
      int         idx;
      if (reset) begin
         grid_reg = GSIZE_RESET;
         expected_samples.delete();
      end else begin
         // register write
         if (psel && penable && pwrite && pready && paddr == {CSR_IDX_GRID_SIZE, 2'b00})
            grid_reg = pwdata[GSIZE_W-1:0];

         // accepted input item
         if (req_valid && req_ready) begin
            span = span_in_use();
            cx = longint'(req_cell_x);
            cz = longint'(req_cell_z);
            case (req_mode) inside
               MODE_WR_HEIGHT, MODE_WR_CUT, MODE_WR_ATTR: begin
                  if (cx >= 0 && cx < span && cz >= 0 && cz < span) begin
                     idx = int'(cx + cz * span);
                     case (req_mode)
                        MODE_WR_HEIGHT: height_mem[idx] = req_height_in;
                        MODE_WR_CUT:    cut_mem[idx] = req_cut_in;
                        default:        attr_mem[idx] = req_attribute_in;
                     endcase
                  end
               end
               MODE_RD_NEAR: begin
                  idx = int'(clamp_l(cx, 0, span - 1) + clamp_l(cz, 0, span - 1) * span);
                  want.height = {2'b00, height_mem[idx]};
                  want.cut    = cut_mem[idx];
                  want.attr   = attr_mem[idx];
                  expected_samples.push_back(want);
               end
               MODE_RD_INTERP: begin
                  want.height = OUT_W'(blend_height(longint'(req_sample_x),
                                                    longint'(req_sample_z), span));
                  want.cut    = 1'b0;
                  want.attr   = '0;
                  expected_samples.push_back(want);
               end
               default: ;
            endcase
         end

         // accepted result item
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               report_mismatch("unrequested result, height", longint'(rsp_height_out), 0);
            end else begin
               want = expected_samples.pop_front();
               if (rsp_height_out !== want.height)
                  report_mismatch("height", longint'(rsp_height_out), longint'(want.height));
               if (rsp_cut_out !== want.cut)
                  report_mismatch("cut", longint'(rsp_cut_out), longint'(want.cut));
               if (rsp_attribute_out !== want.attr)
                  report_mismatch("attribute", longint'(rsp_attribute_out),
                                  longint'(want.attr));
            end
         end
      end
      outstanding <= expected_samples.size();
   end

endmodule

FILE: tb/tb_heightfield_store_sampler.sv
`timescale 1ns / 1ps
module tb_heightfield_store_sampler;
   import hfs_pkg::*;

   localparam int CELLS       = GRID_MAX_DEF * GRID_MAX_DEF;
   localparam int ONE         = 1 << FRAC_BITS_DEF;
   localparam int LONG_HOLD   = 300;
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 80;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [MODE_W-1:0]       req_mode;
   logic signed [CELL_W-1:0]   req_cell_x;
   logic signed [CELL_W-1:0]   req_cell_z;
   logic signed [SAMPLE_W-1:0] req_sample_x;
   logic signed [SAMPLE_W-1:0] req_sample_z;
   logic [HGT_W-1:0]        req_height_in;
   logic                    req_cut_in;
   logic [ATTR_W-1:0]       req_attribute_in;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic signed [OUT_W-1:0] rsp_height_out;
   logic                    rsp_cut_out;
   logic [ATTR_W-1:0]       rsp_attribute_out;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [PADDR_W-1:0]      paddr;
   logic [PDATA_W-1:0]      pwdata;
   logic [PDATA_W-1:0]      prdata;
   logic                    pready;
   int                      fail_count;
   int                      outstanding;

   // which flat entries hold data, so no read touches an unwritten one
   bit height_written [CELLS];
   bit cut_written    [CELLS];
   bit attr_written   [CELLS];
   int span;
   int win_x, win_z, win_w;
   bit no_idle;
   int hold_requests, hold_taken;
   int n_writes, n_near, n_interp, n_dropped, n_sizes;
   int grid_plan [PHASES] = '{2, 0, 7, 511, 1, 33, 256, 255, 3, 0};

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   heightfield_store_sampler u_dut (.*);

   hfs_checker u_checker (.*);

   initial begin
      #2_000_000;
      $display("tb_heightfield_store_sampler: errors");
      $finish;
   end

   function automatic int clamp_int(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic int effective_items();
      return n_writes + n_near + n_interp;
   endfunction

   function automatic int rand_height();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 65535;
         default: return int'($urandom_range(0, 65535));
      endcase
   endfunction

   // cell coordinate, mostly in the working window
   function automatic int cell_coord(int origin);
      if ($urandom_range(0, 3) != 0) return origin + int'($urandom_range(0, win_w - 1));
      return int'($urandom_range(0, 8191)) - 4096;
   endfunction

   // fixed-point coordinate, mostly in the working window
   function automatic int sample_coord(int origin);
      if ($urandom_range(0, 4) != 0)
         return origin * ONE + int'($urandom_range(0, win_w * ONE - 1));
      return int'($urandom_range(0, 2097151)) - 1048576;
   endfunction

   // result side: random hold before each item, long hold on request
   initial begin : result_drain
      int hold;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_requests > hold_taken) begin
            hold = LONG_HOLD;
            hold_taken++;
         end else if (no_idle) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 11);
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input int cx, input int cz,
                            input int sx, input int sz, input int hin, input int cin,
                            input int ain);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_cell_x       <= CELL_W'(cx);
      req_cell_z       <= CELL_W'(cz);
      req_sample_x     <= SAMPLE_W'(sx);
      req_sample_z     <= SAMPLE_W'(sz);
      req_height_in    <= HGT_W'(hin);
      req_cut_in       <= cin[0];
      req_attribute_in <= ATTR_W'(ain);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_cell(input logic [MODE_W-1:0] mode, input int cx, input int cz,
                             input int val);
      int hin, cin, ain, idx;
      bit on_grid;
      hin = $urandom;
      cin = $urandom;
      ain = $urandom;
      case (mode)
         MODE_WR_HEIGHT: hin = val;
         MODE_WR_CUT:    cin = val;
         default:        ain = val;
      endcase
      send_item(mode, cx, cz, $urandom, $urandom, hin, cin, ain);
      on_grid = cx >= 0 && cx < span && cz >= 0 && cz < span;
      if (on_grid) begin
         idx = cx + cz * span;
         case (mode)
            MODE_WR_HEIGHT: height_written[idx] = 1'b1;
            MODE_WR_CUT:    cut_written[idx] = 1'b1;
            default:        attr_written[idx] = 1'b1;
         endcase
         n_writes++;
      end else begin
         n_dropped++;
      end
   endtask

   task automatic ensure_height(input int cx, input int cz);
      if (!height_written[cx + cz * span]) write_cell(MODE_WR_HEIGHT, cx, cz, rand_height());
   endtask

   task automatic ensure_cell(input int cx, input int cz);
      ensure_height(cx, cz);
      if (!cut_written[cx + cz * span])
         write_cell(MODE_WR_CUT, cx, cz, $urandom_range(0, 1));
      if (!attr_written[cx + cz * span])
         write_cell(MODE_WR_ATTR, cx, cz, $urandom_range(0, 255));
   endtask

   task automatic read_nearest(input int cx, input int cz);
      ensure_cell(clamp_int(cx, 0, span - 1), clamp_int(cz, 0, span - 1));
      send_item(MODE_RD_NEAR, cx, cz, $urandom, $urandom, $urandom, $urandom, $urandom);
      n_near++;
   endtask

   task automatic read_interp(input int sx, input int sz);
      int ix, iz;
      ix = clamp_int(sx >>> FRAC_BITS_DEF, 0, span - 2);
      iz = clamp_int(sz >>> FRAC_BITS_DEF, 0, span - 2);
      ensure_height(ix, iz);
      ensure_height(ix + 1, iz);
      ensure_height(ix, iz + 1);
      ensure_height(ix + 1, iz + 1);
      send_item(MODE_RD_INTERP, $urandom, $urandom, sx, sz, $urandom, $urandom, $urandom);
      n_interp++;
   endtask

   // stop offering items and let every result and pending write drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_grid(input int val);
      wait_idle();
      csr_write({CSR_IDX_GRID_SIZE, 2'b00}, PDATA_W'(val));
      span  = clamp_int(val, 2, GRID_MAX_DEF);
      win_w = (span < 16) ? span : 16;
      win_x = $urandom_range(0, span - win_w);
      win_z = $urandom_range(0, span - win_w);
      n_sizes++;
   endtask

   task automatic random_item();
      int pick, val;
      logic [MODE_W-1:0] mode;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         case ($urandom_range(0, 2))
            0: begin
               mode = MODE_WR_HEIGHT;
               val  = rand_height();
            end
            1: begin
               mode = MODE_WR_CUT;
               val  = $urandom_range(0, 1);
            end
            default: begin
               mode = MODE_WR_ATTR;
               val  = $urandom_range(0, 255);
            end
         endcase
         write_cell(mode, cell_coord(win_x), cell_coord(win_z), val);
      end else if (pick < 55) begin
         read_nearest(cell_coord(win_x), cell_coord(win_z));
      end else if (pick < 93) begin
         read_interp(sample_coord(win_x), sample_coord(win_z));
      end else begin
         // unused modes give nothing
         mode = MODE_RD_INTERP + MODE_W'($urandom_range(1, 3));
         send_item(mode, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
         n_dropped++;
      end
   endtask

   initial begin : stimulus
      int guard, stop, burst_at;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = '0;
      req_cell_x       = '0;
      req_cell_z       = '0;
      req_sample_x     = '0;
      req_sample_z     = '0;
      req_height_in    = '0;
      req_cut_in       = 1'b0;
      req_attribute_in = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      no_idle          = 1'b0;
      span  = clamp_int(int'(GSIZE_RESET), 2, GRID_MAX_DEF);
      win_w = 16;
      win_x = 0;
      win_z = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: corner cells at the reset size
      write_cell(MODE_WR_HEIGHT, 0, 0, 65535);
      write_cell(MODE_WR_CUT, 0, 0, 1);
      write_cell(MODE_WR_ATTR, 0, 0, 255);
      write_cell(MODE_WR_HEIGHT, 1, 0, 0);
      write_cell(MODE_WR_HEIGHT, 0, 1, 32768);
      write_cell(MODE_WR_HEIGHT, 1, 1, 1);
      // writes off the grid and an unused mode are dropped
      write_cell(MODE_WR_HEIGHT, -1, 0, 7);
      write_cell(MODE_WR_ATTR, 256, 0, 9);
      write_cell(MODE_WR_CUT, -4096, 4095, 1);
      send_item(MODE_RD_INTERP + MODE_W'(3), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom);
      n_dropped++;
      // nearest reads, in and clamped from both extremes
      read_nearest(0, 0);
      read_nearest(-4096, -4096);
      read_nearest(4095, 4095);
      // interpolation on both triangles, the diagonal and far outside
      read_interp(0, 0);
      read_interp(128, 64);
      read_interp(64, 128);
      read_interp(100, 100);
      read_interp(-1048576, -1048576);
      read_interp(1048575, 1048575);
      read_interp(1048575, -1048576);

      // random phases over grid sizes
      for (int p = 0; p < PHASES; p++) begin
         set_grid((p == PHASES - 1) ? int'($urandom_range(0, 511)) : grid_plan[p]);
         stop     = effective_items() + PHASE_ITEMS;
         burst_at = effective_items() + 40;
         while (effective_items() < stop) begin
            no_idle = effective_items() >= burst_at && effective_items() < burst_at + 25;
            random_item();
         end
         no_idle = 1'b0;
         // back-to-back reads against a long result stall
         if (p == 2 || p == 6) begin
            hold_requests++;
            no_idle = 1'b1;
            repeat (40) begin
               if ($urandom_range(0, 1)) read_nearest(cell_coord(win_x), cell_coord(win_z));
               else read_interp(sample_coord(win_x), sample_coord(win_z));
            end
            no_idle = 1'b0;
         end
      end

      // drain
      req_valid <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (outstanding != 0 && guard < 5000);
      repeat (20) @(posedge clock);

      $display("covered %0d writes, %0d nearest and %0d interpolated reads, %0d dropped items",
               n_writes, n_near, n_interp, n_dropped);
      $display("over %0d grid size settings, the reset size and sizes 0, 1, 2 and 511 included",
               n_sizes);
      if (fail_count == 0 && outstanding == 0) begin
         $display("tb_heightfield_store_sampler: clean");
      end else begin
         $display("tb_heightfield_store_sampler: errors");
      end
      $finish;
   end

endmodule
